### src/r2fft_pkg.sv
package r2fft_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SIZE   = 2'd0,
        CFG_WINDOW = 2'd1,
        CFG_RATE   = 2'd2
    } t_cfg_idx;

    // Fixed widths of the configuration and result fields.
    localparam int CFG_W   = 24;
    localparam int SIZE_W  = 3;
    localparam int RATE_W  = 24;
    localparam int INDEX_W = 6;
    localparam int FREQ_W  = 27;
    localparam int MAG_W   = 24;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd7;
    localparam logic [RATE_W-1:0] RATE_RESET = 24'd48000;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_take;
        logic win_mul;
        logic load_wr;
        logic pad_wr;
        logic bf_cap_a;
        logic bf_mul;
        logic bf_add;
        logic bf_wr1;
        logic bf_wr2;
        logic mg_sq;
        logic mg_sum;
        logic mg_step;
        logic mg_out;
        logic mg_last;
    } t_cmd;

endpackage

### src/radix2_fft_magnitude_spectrum.sv
// Load: take, window, store; busy stays high from start until the sample is stored.
// A closing sample zero-fills the rest of the frame (N - loaded points), then the transform
// runs log2(N) stages of N/2 butterflies, one butterfly at a time on the frame store's single read port.
// Each of the N/2 bins then passes read, square, sum, a 32-step square root and output.
// Bins appear one per strobe and cannot be stalled.
// Reset (synchronous, active low) clears the sequencer and sets size 7, no window, 48000 Hz.
module radix2_fft_magnitude_spectrum #(
    parameter int MAX_LOG2     = 7,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic                                  i_frame_end,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [r2fft_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                  o_bin_valid,
    output logic [r2fft_pkg::INDEX_W-1:0]         o_bin_index,
    output logic [r2fft_pkg::FREQ_W-1:0]          o_bin_frequency,
    output logic [r2fft_pkg::MAG_W-1:0]           o_magnitude,
    output logic                                  o_last_bin
);

    localparam int AW   = MAX_LOG2;
    localparam int HW   = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1;
    localparam int LG_W = $clog2(MAX_LOG2 + 1);

    logic [r2fft_pkg::SIZE_W-1:0] r_size;
    logic                         r_win;
    logic [r2fft_pkg::RATE_W-1:0] r_rate;
    logic [LG_W-1:0]              eff_lg;
    logic                         size_wr;

    r2fft_pkg::t_cmd  cmd;
    logic [AW-1:0]    raddr, waddr;
    logic [HW-1:0]    tw_idx, bin;
    logic [AW:0]      win_idx;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= r2fft_pkg::SIZE_RESET;
            r_win  <= 1'b0;
            r_rate <= r2fft_pkg::RATE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                r2fft_pkg::CFG_SIZE:   r_size <= i_cfg_data[r2fft_pkg::SIZE_W-1:0];
                r2fft_pkg::CFG_WINDOW: r_win  <= i_cfg_data[0];
                r2fft_pkg::CFG_RATE:   r_rate <= i_cfg_data[r2fft_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    assign size_wr = i_cfg_we && (i_cfg_index == r2fft_pkg::CFG_SIZE);

    // Frame size clamped to 1..MAX_LOG2.
    always_comb begin
        if (r_size == '0) begin
            eff_lg = LG_W'(1);
        end else if (int'(r_size) > MAX_LOG2) begin
            eff_lg = LG_W'(MAX_LOG2);
        end else begin
            eff_lg = LG_W'(r_size);
        end
    end

    r2fft_ctrl #(
        .MAX_LOG2 (MAX_LOG2)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_frame_end (i_frame_end),
        .i_size_wr   (size_wr),
        .i_lg        (eff_lg),
        .o_busy      (o_busy),
        .o_cmd       (cmd),
        .o_raddr     (raddr),
        .o_waddr     (waddr),
        .o_tw_idx    (tw_idx),
        .o_bin       (bin),
        .o_win_idx   (win_idx)
    );

    r2fft_dp #(
        .MAX_LOG2     (MAX_LOG2),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_raddr   (raddr),
        .i_waddr   (waddr),
        .i_tw_idx  (tw_idx),
        .i_bin     (bin),
        .i_win_idx (win_idx),
        .i_lg      (eff_lg),
        .i_win_en  (r_win),
        .i_rate    (r_rate),
        .i_sample  (i_sample),
        .o_valid   (o_bin_valid),
        .o_index   (o_bin_index),
        .o_freq    (o_bin_frequency),
        .o_mag     (o_magnitude),
        .o_last    (o_last_bin)
    );

`ifndef SYNTHESIS
    // A taken request always makes the block busy in the next cycle.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but block not busy");

    // Bins only come out of a running frame.
    a_bin_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bin_valid |-> $past(o_busy))
        else $error("bin strobe outside a frame");

    // The last bin closes the frame's output.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin_valid && o_last_bin) |=> !o_bin_valid)
        else $error("bin strobe right after last bin");
`endif

endmodule

### src/r2fft_ram.sv
module r2fft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/r2fft_ctrl.sv
module r2fft_ctrl #(
    parameter int MAX_LOG2 = 7,
    localparam int AW   = MAX_LOG2,
    localparam int HW   = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1,
    localparam int LG_W = $clog2(MAX_LOG2 + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_frame_end,
    input  logic              i_size_wr,
    input  logic [LG_W-1:0]   i_lg,
    output logic              o_busy,
    output r2fft_pkg::t_cmd   o_cmd,
    output logic [AW-1:0]     o_raddr,
    output logic [AW-1:0]     o_waddr,
    output logic [HW-1:0]     o_tw_idx,
    output logic [HW-1:0]     o_bin,
    output logic [AW:0]       o_win_idx
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_LD_MUL  = 15'h0002,
        S_LD_WR   = 15'h0004,
        S_PAD     = 15'h0008,
        S_BF_RD1  = 15'h0010,
        S_BF_RD2  = 15'h0020,
        S_BF_MUL  = 15'h0040,
        S_BF_ADD  = 15'h0080,
        S_BF_WR1  = 15'h0100,
        S_BF_WR2  = 15'h0200,
        S_MG_RD   = 15'h0400,
        S_MG_SQ   = 15'h0800,
        S_MG_SUM  = 15'h1000,
        S_MG_ROOT = 15'h2000,
        S_MG_OUT  = 15'h4000
    } t_state;

    localparam logic [4:0] LAST_STEP = 5'd31;

    t_state          r_state, n_state;
    logic [AW:0]     r_cnt, n_cnt;
    logic            r_fe, n_fe;
    logic [LG_W-1:0] r_stage, n_stage;
    logic [AW-1:0]   r_bf, n_bf;
    logic [AW-1:0]   r_bin, n_bin;
    logic [4:0]      r_step, n_step;

    logic [AW:0]     cnt_inc;
    logic [AW:0]     n_pts;
    logic            frame_full;
    logic [AW-1:0]   rev_full;
    logic [AW-1:0]   pos;
    logic [AW-1:0]   half;
    logic [AW-1:0]   half_n;
    logic [AW-1:0]   kk;
    logic [AW-1:0]   i1;
    logic [AW-1:0]   i2;
    logic            bf_last;
    logic            bin_last;

    // Frame counting and the bit-reversed store position.
    always_comb begin
        cnt_inc    = r_cnt + (AW+1)'(1);
        n_pts      = (AW+1)'(1) << i_lg;
        frame_full = (cnt_inc == n_pts);
        for (int i = 0; i < AW; i++) begin
            rev_full[i] = r_cnt[AW-1-i];
        end
        pos = rev_full >> (AW - int'(i_lg));
    end

    // Butterfly addressing for the current stage.
    always_comb begin
        half     = AW'(1) << (r_stage - LG_W'(1));
        half_n   = AW'(1) << (i_lg - LG_W'(1));
        kk       = r_bf & (half - AW'(1));
        i1       = ((r_bf >> (r_stage - LG_W'(1))) << r_stage) | kk;
        i2       = i1 | half;
        bf_last  = (r_bf == half_n - AW'(1));
        bin_last = (r_bin == half_n - AW'(1));
    end

    assign o_tw_idx  = HW'(kk << (AW - int'(r_stage)));
    assign o_bin     = HW'(r_bin);
    assign o_win_idx = ((AW+1)'(1) << i_lg) | r_cnt;
    assign o_busy    = (r_state != S_IDLE);

    // Memory addresses by state.
    always_comb begin
        unique case (r_state)
            S_BF_RD1, S_BF_WR1: begin
                o_raddr = i1;
                o_waddr = i1;
            end
            S_BF_RD2, S_BF_WR2: begin
                o_raddr = i2;
                o_waddr = i2;
            end
            default: begin
                o_raddr = r_bin;
                o_waddr = pos;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_take = (r_state == S_IDLE) && i_start;
        o_cmd.win_mul   = (r_state == S_LD_MUL);
        o_cmd.load_wr   = (r_state == S_LD_WR);
        o_cmd.pad_wr    = (r_state == S_PAD);
        o_cmd.bf_cap_a  = (r_state == S_BF_RD2);
        o_cmd.bf_mul    = (r_state == S_BF_MUL);
        o_cmd.bf_add    = (r_state == S_BF_ADD);
        o_cmd.bf_wr1    = (r_state == S_BF_WR1);
        o_cmd.bf_wr2    = (r_state == S_BF_WR2);
        o_cmd.mg_sq     = (r_state == S_MG_SQ);
        o_cmd.mg_sum    = (r_state == S_MG_SUM);
        o_cmd.mg_step   = (r_state == S_MG_ROOT);
        o_cmd.mg_out    = (r_state == S_MG_OUT);
        o_cmd.mg_last   = bin_last;
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_fe    = r_fe;
        n_stage = r_stage;
        n_bf    = r_bf;
        n_bin   = r_bin;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_fe    = i_frame_end;
                    n_state = S_LD_MUL;
                end
            end
            S_LD_MUL: begin
                n_state = S_LD_WR;
            end
            S_LD_WR, S_PAD: begin
                if (frame_full) begin
                    n_cnt   = '0;
                    n_stage = LG_W'(1);
                    n_bf    = '0;
                    n_state = S_BF_RD1;
                end else begin
                    n_cnt   = cnt_inc;
                    n_state = (r_fe || r_state == S_PAD) ? S_PAD : S_IDLE;
                end
            end
            S_BF_RD1: n_state = S_BF_RD2;
            S_BF_RD2: n_state = S_BF_MUL;
            S_BF_MUL: n_state = S_BF_ADD;
            S_BF_ADD: n_state = S_BF_WR1;
            S_BF_WR1: n_state = S_BF_WR2;
            S_BF_WR2: begin
                if (bf_last) begin
                    n_bf = '0;
                    if (r_stage == i_lg) begin
                        n_bin   = '0;
                        n_state = S_MG_RD;
                    end else begin
                        n_stage = r_stage + LG_W'(1);
                        n_state = S_BF_RD1;
                    end
                end else begin
                    n_bf    = r_bf + AW'(1);
                    n_state = S_BF_RD1;
                end
            end
            S_MG_RD: n_state = S_MG_SQ;
            S_MG_SQ: n_state = S_MG_SUM;
            S_MG_SUM: begin
                n_step  = '0;
                n_state = S_MG_ROOT;
            end
            S_MG_ROOT: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_MG_OUT;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_MG_OUT: begin
                if (bin_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_bin   = r_bin + AW'(1);
                    n_state = S_MG_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // A new frame size drops the partial frame.
        if (i_size_wr) begin
            n_cnt = '0;
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fe    <= 1'b0;
            r_stage <= LG_W'(1);
            r_bf    <= '0;
            r_bin   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fe    <= n_fe;
            r_stage <= n_stage;
            r_bf    <= n_bf;
            r_bin   <= n_bin;
            r_step  <= n_step;
        end
    end

endmodule

### src/r2fft_dp.sv
module r2fft_dp #(
    parameter int MAX_LOG2     = 7,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16,
    localparam int AW   = MAX_LOG2,
    localparam int HW   = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1,
    localparam int LG_W = $clog2(MAX_LOG2 + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  r2fft_pkg::t_cmd                       i_cmd,
    input  logic [AW-1:0]                         i_raddr,
    input  logic [AW-1:0]                         i_waddr,
    input  logic [HW-1:0]                         i_tw_idx,
    input  logic [HW-1:0]                         i_bin,
    input  logic [AW:0]                           i_win_idx,
    input  logic [LG_W-1:0]                       i_lg,
    input  logic                                  i_win_en,
    input  logic [r2fft_pkg::RATE_W-1:0]          i_rate,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    output logic                                  o_valid,
    output logic [r2fft_pkg::INDEX_W-1:0]         o_index,
    output logic [r2fft_pkg::FREQ_W-1:0]          o_freq,
    output logic [r2fft_pkg::MAG_W-1:0]           o_mag,
    output logic                                  o_last
);

    localparam int TW    = TWIDDLE_BITS;
    localparam int PW    = SAMPLE_BITS + TWIDDLE_BITS;
    localparam int MW    = 32 + TWIDDLE_BITS;
    localparam int OW    = 34;
    localparam int FPW   = HW + r2fft_pkg::RATE_W;
    localparam int TWN   = 2 ** HW;
    localparam int WINN  = 2 ** (AW + 1);
    localparam int DEPTH = 2 ** AW;
    // Scale 2/N with 8 fraction bits is a shift by 9 - log2 N.
    localparam int MAG_REF = 9;

    localparam longint unsigned ONE_Q30   = 64'd1 << 30;
    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam longint unsigned QUARTER   = 64'h4000_0000;
    localparam longint unsigned TURN_MASK = 64'hFFFF_FFFF;
    localparam logic [r2fft_pkg::MAG_W-1:0] MAG_CAP = '1;

    // Q30 sine of a 32-bit phase by a truncated Taylor series.
    function automatic longint sin_q30(longint unsigned phase);
        longint unsigned p, quad, r, x, t, b, s, d;
        p    = phase & TURN_MASK;
        quad = p >> 30;
        r    = p & (ONE_Q30 - 1);
        if (quad[0]) r = ONE_Q30 - r;
        x = (r * PI_Q30) >> 31;
        t = (x * x) >> 30;
        b = ONE_Q30;
        for (int i = 0; i < 6; i++) begin
            d = (t * b) >> 30;
            case (i)
                0:       d = d / 156;
                1:       d = d / 110;
                2:       d = d / 72;
                3:       d = d / 42;
                4:       d = d / 20;
                default: d = d / 6;
            endcase
            b = (d > ONE_Q30) ? 64'd0 : ONE_Q30 - d;
        end
        s = (x * b) >> 30;
        if (s > ONE_Q30) s = ONE_Q30;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // Round a Q30 value to a saturated coefficient.
    function automatic logic signed [TW-1:0] to_coef(longint v30);
        longint q, hi, lo;
        hi = (longint'(1) <<< (TW - 1)) - 1;
        lo = -(longint'(1) <<< (TW - 1));
        q  = (v30 + (longint'(1) <<< (30 - TW))) >>> (31 - TW);
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return TW'(q);
    endfunction

    function automatic longint hann_q30(longint unsigned phase);
        longint c;
        c = sin_q30(phase + QUARTER);
        return (longint'(ONE_Q30) - c) >>> 1;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -35'sh0_8000_0000) return -32'sh8000_0000;
        return 32'(v);
    endfunction

    // Twiddle table: entry j is the angle j / 2^MAX_LOG2 of a turn.
    logic signed [TW-1:0] w_cos [TWN];
    logic signed [TW-1:0] w_sin [TWN];
    for (genvar j = 0; j < TWN; j++) begin : g_tw
        localparam longint unsigned PH = (longint'(j) << (32 - AW)) & TURN_MASK;
        assign w_cos[j] = to_coef(sin_q30(PH + QUARTER));
        assign w_sin[j] = to_coef(sin_q30(PH));
    end

    // Hann table: entry 2^lg + n holds the weight of point n in an N = 2^lg frame.
    logic signed [TW-1:0] w_win [WINN];
    assign w_win[0] = '0;
    assign w_win[1] = '0;
    for (genvar gl = 1; gl <= AW; gl++) begin : g_wl
        for (genvar gc = 0; gc < 2 ** gl; gc++) begin : g_wc
            localparam longint unsigned PH =
                ((longint'(gc) << 32) / longint'((2 ** gl) - 1)) & TURN_MASK;
            assign w_win[(2 ** gl) + gc] = to_coef(hann_q30(PH));
        end
    end

    logic [63:0]               rdata;
    logic                      we;
    logic [63:0]               wdata;
    logic signed [31:0]        rd_re, rd_im;
    logic signed [31:0]        a_re, a_im;

    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [PW-1:0]      r_prod;
    logic signed [PW:0]        ld_full;
    logic signed [31:0]        ld_re;
    logic [63:0]               r_a;
    logic signed [MW-1:0]      r_p1, r_p2, r_p3, r_p4;
    logic signed [OW-1:0]      r_or, r_oi;
    logic signed [MW:0]        sum_r, sum_i;
    logic [31:0]               abs_re, abs_im;
    logic [63:0]               r_sqr, r_sqi;
    logic [FPW-1:0]            r_fprod;
    logic [63:0]               pwr;
    logic [63:0]               r_rad, r_res, r_root_bit;
    logic [63:0]               trial;
    logic                      r_capf;
    logic [63:0]               root_scaled;
    logic [FPW+3:0]            fscaled;
    logic                      r_valid, r_last;
    logic [r2fft_pkg::INDEX_W-1:0] r_index;
    logic [r2fft_pkg::FREQ_W-1:0]  r_freq;
    logic [r2fft_pkg::MAG_W-1:0]   r_mag;

    // Frame store, real part above imaginary part.
    r2fft_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_waddr),
        .i_wdata (wdata),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    assign rd_re = rdata[63:32];
    assign rd_im = rdata[31:0];
    assign a_re  = r_a[63:32];
    assign a_im  = r_a[31:0];

    // Windowed sample, rounded back to input scale.
    assign ld_full = ((PW+1)'(r_prod) + ((PW+1)'(1) <<< (TW - 2))) >>> (TW - 1);
    assign ld_re   = 32'(ld_full);

    // Store write selection.
    always_comb begin
        we    = i_cmd.load_wr | i_cmd.pad_wr | i_cmd.bf_wr1 | i_cmd.bf_wr2;
        wdata = '0;
        if (i_cmd.load_wr) begin
            wdata = {ld_re, 32'd0};
        end else if (i_cmd.bf_wr1) begin
            wdata = {sat32(35'(a_re) + 35'(r_or)), sat32(35'(a_im) + 35'(r_oi))};
        end else if (i_cmd.bf_wr2) begin
            wdata = {sat32(35'(a_re) - 35'(r_or)), sat32(35'(a_im) - 35'(r_oi))};
        end
    end

    // Sample capture, windowing and butterfly arithmetic.
    assign sum_r = (MW+1)'(r_p1) - (MW+1)'(r_p2) + ((MW+1)'(1) <<< (TW - 2));
    assign sum_i = (MW+1)'(r_p3) + (MW+1)'(r_p4) + ((MW+1)'(1) <<< (TW - 2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_take) begin
            r_smp <= i_sample;
        end
        if (i_cmd.win_mul) begin
            r_prod <= i_win_en ? PW'(r_smp) * PW'(w_win[i_win_idx])
                               : (PW'(r_smp) <<< (TW - 1));
        end
        if (i_cmd.bf_cap_a) begin
            r_a <= rdata;
        end
        if (i_cmd.bf_mul) begin
            r_p1 <= MW'(w_cos[i_tw_idx]) * MW'(rd_re);
            r_p2 <= MW'(w_sin[i_tw_idx]) * MW'(rd_im);
            r_p3 <= MW'(w_cos[i_tw_idx]) * MW'(rd_im);
            r_p4 <= MW'(w_sin[i_tw_idx]) * MW'(rd_re);
        end
        if (i_cmd.bf_add) begin
            r_or <= OW'(sum_r >>> (TW - 1));
            r_oi <= OW'(sum_i >>> (TW - 1));
        end
    end

    // Magnitude: squares, scaling, then a bit-serial square root.
    assign abs_re = rd_re[31] ? 32'(-rd_re) : 32'(rd_re);
    assign abs_im = rd_im[31] ? 32'(-rd_im) : 32'(rd_im);
    assign pwr    = r_sqr + r_sqi;
    assign trial  = r_res + r_root_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mg_sq) begin
            r_sqr   <= 64'(abs_re) * 64'(abs_re);
            r_sqi   <= 64'(abs_im) * 64'(abs_im);
            r_fprod <= FPW'(i_bin) * FPW'(i_rate);
        end
        if (i_cmd.mg_sum) begin
            r_res      <= '0;
            r_root_bit <= 64'd1 << 62;
            if (int'(i_lg) <= MAG_REF) begin
                r_rad  <= pwr << (2 * (MAG_REF - int'(i_lg)));
                r_capf <= (pwr >> (48 - 2 * (MAG_REF - int'(i_lg)))) != 64'd0;
            end else begin
                r_rad  <= pwr;
                r_capf <= 1'b0;
            end
        end
        if (i_cmd.mg_step) begin
            r_root_bit <= r_root_bit >> 2;
            if (r_rad >= trial) begin
                r_rad <= r_rad - trial;
                r_res <= (r_res >> 1) + r_root_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign root_scaled = (int'(i_lg) <= MAG_REF) ? r_res : (r_res >> (int'(i_lg) - MAG_REF));
    assign fscaled     = {r_fprod, 4'b0000} >> i_lg;

    // Result register: one strobe per bin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= i_cmd.mg_out;
            r_last  <= i_cmd.mg_out & i_cmd.mg_last;
        end
        if (i_cmd.mg_out) begin
            r_index <= r2fft_pkg::INDEX_W'(i_bin);
            r_freq  <= r2fft_pkg::FREQ_W'(fscaled);
            r_mag   <= (r_capf || root_scaled > 64'(MAG_CAP)) ? MAG_CAP
                                                             : r2fft_pkg::MAG_W'(root_scaled);
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_index = r_index;
    assign o_freq  = r_freq;
    assign o_mag   = r_mag;

endmodule

### verif/radix2_fft_magnitude_spectrum_tb.sv
`timescale 1ns / 100ps

// Scoreboard: holds its own copy of the frame store and registers, predicts
// the spectrum of each closed frame and checks the bins against it.
class spectrum_scoreboard;
    typedef struct {
        bit [5:0]  idx;
        bit [26:0] freq;
        bit [23:0] mag;
        bit        last;
    } t_bin;

    localparam longint unsigned ONE_Q30  = 64'd1 << 30;
    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint unsigned QUARTER  = 64'h4000_0000;
    localparam longint unsigned TURN     = 64'hFFFF_FFFF;

    t_bin     bin_q[$];
    int       errors;
    int       bins_seen;
    int       frames_closed;
    bit [2:0] size_reg;
    bit       win_reg;
    bit [23:0] rate_reg;
    int       fill;
    longint   re_mem[128];
    longint   im_mem[128];

    function new();
        size_reg = 3'd7;
        win_reg  = 1'b0;
        rate_reg = 24'd48000;
        fill     = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH %0t: %s", $time, msg);
        errors++;
    endtask

    // Register writes; an unused index is ignored.
    function void write_reg(logic [1:0] idx, logic [23:0] d);
        case (idx)
            r2fft_pkg::CFG_SIZE: begin
                size_reg = d[2:0];
                fill = 0;
            end
            r2fft_pkg::CFG_WINDOW: win_reg = d[0];
            r2fft_pkg::CFG_RATE: rate_reg = d;
            default: ;
        endcase
    endfunction

    function int frame_log2();
        if (size_reg < 1) return 1;
        return int'(size_reg);
    endfunction

    // Quadrant-folded polynomial sine in Q30 of a 32-bit phase.
    function longint sine_q30(longint unsigned phase);
        longint unsigned p, r, x, t, b, s, d, quad;
        longint unsigned divs[6];
        divs = '{156, 110, 72, 42, 20, 6};
        p = phase & TURN;
        quad = p >> 30;
        r = p & (ONE_Q30 - 1);
        if (quad[0]) r = ONE_Q30 - r;
        x = (r * PI_Q30) >> 31;
        t = (x * x) >> 30;
        b = ONE_Q30;
        for (int i = 0; i < 6; i++) begin
            d = ((t * b) >> 30) / divs[i];
            b = (d > ONE_Q30) ? 64'd0 : ONE_Q30 - d;
        end
        s = (x * b) >> 30;
        if (s > ONE_Q30) s = ONE_Q30;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // Round a Q30 value to a Q15 coefficient and saturate it.
    function longint coef_q15(longint v30);
        longint q;
        q = (v30 + (64'sd1 <<< 14)) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function int reverse_bits(int v, int bits);
        int r;
        r = 0;
        for (int i = 0; i < bits; i++) r |= ((v >> i) & 1) << (bits - 1 - i);
        return r;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned rem, res, bv;
        rem = v;
        res = 0;
        bv = 64'd1 << 62;
        while (bv > rem) bv >>= 2;
        while (bv != 0) begin
            if (rem >= res + bv) begin
                rem -= res + bv;
                res = (res >> 1) + bv;
            end else begin
                res >>= 1;
            end
            bv >>= 2;
        end
        return res;
    endfunction

    function longint unsigned mag_of(longint re, longint im, int lg);
        longint unsigned ar, ai, p, m;
        int sh;
        ar = (re < 0) ? -re : re;
        ai = (im < 0) ? -im : im;
        p = ar * ar + ai * ai;
        sh = 9 - lg;
        if (p >= (64'd1 << (48 - 2 * sh))) return 64'hFF_FFFF;
        m = int_sqrt(p << (2 * sh));
        return (m > 64'hFF_FFFF) ? 64'hFF_FFFF : m;
    endfunction

    // In-place decimation-in-time transform over the bit-reversed frame.
    function void transform(int lg, int n);
        int half, i1, i2;
        longint unsigned ph;
        longint tr, ti, br, bi, er, ei, pr, pi;
        for (int s = 1; s <= lg; s++) begin
            half = 1 << (s - 1);
            for (int base = 0; base < n; base += 2 * half) begin
                for (int k = 0; k < half; k++) begin
                    i1 = base + k;
                    i2 = base + k + half;
                    ph = (longint'(k) << (32 - s)) & TURN;
                    tr = coef_q15(sine_q30(ph + QUARTER));
                    ti = coef_q15(sine_q30(ph));
                    br = re_mem[i2];
                    bi = im_mem[i2];
                    er = re_mem[i1];
                    ei = im_mem[i1];
                    pr = (tr * br - ti * bi + (64'sd1 <<< 14)) >>> 15;
                    pi = (tr * bi + ti * br + (64'sd1 <<< 14)) >>> 15;
                    re_mem[i1] = clip32(er + pr);
                    im_mem[i1] = clip32(ei + pi);
                    re_mem[i2] = clip32(er - pr);
                    im_mem[i2] = clip32(ei - pi);
                end
            end
        end
    endfunction

    // Store one accepted request; a closing request queues the frame's bins.
    function void note_sample(logic signed [15:0] smp, logic fe);
        int lg, n, pos;
        longint v, c30, hann30;
        longint unsigned ph;
        t_bin b;
        lg = frame_log2();
        n = 1 << lg;
        v = longint'(smp);
        if (fill >= n) fill = 0;
        if (win_reg) begin
            ph = ((longint'(fill) << 32) / longint'(n - 1)) & TURN;
            c30 = sine_q30(ph + QUARTER);
            hann30 = (longint'(ONE_Q30) - c30) >>> 1;
            v = (v * coef_q15(hann30) + (64'sd1 <<< 14)) >>> 15;
        end
        pos = reverse_bits(fill, lg);
        re_mem[pos] = clip32(v);
        im_mem[pos] = 0;
        fill++;
        if (!fe && fill < n) return;
        // Zero padding of the rest of the frame.
        for (; fill < n; fill++) begin
            pos = reverse_bits(fill, lg);
            re_mem[pos] = 0;
            im_mem[pos] = 0;
        end
        fill = 0;
        frames_closed++;
        transform(lg, n);
        for (int k = 0; k < n / 2; k++) begin
            b.idx  = 6'(k);
            b.freq = 27'(((longint'(k) * rate_reg) << 4) >> lg);
            b.mag  = 24'(mag_of(re_mem[k], im_mem[k], lg));
            b.last = (k == n / 2 - 1);
            bin_q = {bin_q, b};
        end
    endfunction

    task check_bin(bit [5:0] idx, bit [26:0] freq, bit [23:0] mag, bit last);
        t_bin w;
        bins_seen++;
        if (bin_q.size() == 0) begin
            report($sformatf("unexpected bin %0d", idx));
            return;
        end
        w = bin_q.pop_front();
        if (idx != w.idx) report($sformatf("bin index %0d, want %0d", idx, w.idx));
        if (freq != w.freq)
            report($sformatf("bin %0d frequency %0d, want %0d", w.idx, freq, w.freq));
        if (mag != w.mag)
            report($sformatf("bin %0d magnitude %0d, want %0d", w.idx, mag, w.mag));
        if (last != w.last)
            report($sformatf("bin %0d last flag %0b, want %0b", w.idx, last, w.last));
    endtask

    function int pending();
        return bin_q.size();
    endfunction
endclass

module radix2_fft_magnitude_spectrum_tb;

    // Index outside the register list, used to check that it is ignored.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_start;
    logic                              o_busy;
    logic signed [15:0]                i_sample;
    logic                              i_frame_end;
    logic                              i_cfg_we;
    logic [1:0]                        i_cfg_index;
    logic [r2fft_pkg::CFG_W-1:0]       i_cfg_data;
    logic                              o_bin_valid;
    logic [r2fft_pkg::INDEX_W-1:0]     o_bin_index;
    logic [r2fft_pkg::FREQ_W-1:0]      o_bin_frequency;
    logic [r2fft_pkg::MAG_W-1:0]       o_magnitude;
    logic                              o_last_bin;

    spectrum_scoreboard sb;
    int                 samples_sent;

    radix2_fft_magnitude_spectrum u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_sample        (i_sample),
        .i_frame_end     (i_frame_end),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_bin_valid     (o_bin_valid),
        .o_bin_index     (o_bin_index),
        .o_bin_frequency (o_bin_frequency),
        .o_magnitude     (o_magnitude),
        .o_last_bin      (o_last_bin)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Every strobed bin is checked against the oldest predicted one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_bin_valid)
            sb.check_bin(o_bin_index, o_bin_frequency, o_magnitude, o_last_bin);
    end

    // Present one request and hold it until the block takes it.
    task automatic put_sample(input logic signed [15:0] smp, input logic fe,
                              input int idle_pct);
        int gap;
        i_start     <= 1'b1;
        i_sample    <= smp;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_busy);
        sb.note_sample(smp, fe);
        samples_sent++;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let every predicted bin come out, then give a pending store time to finish.
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One register write; the enable drops for a cycle before the next write.
    task automatic write_reg(input logic [1:0] idx, input logic [r2fft_pkg::CFG_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int items, input int idle_pct);
        logic signed [15:0] smp;
        write_reg(r2fft_pkg::CFG_SIZE, 24'($urandom_range(1, 7)));
        write_reg(r2fft_pkg::CFG_WINDOW, 24'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0: write_reg(r2fft_pkg::CFG_RATE, 24'hFF_FFFF);
            1: write_reg(r2fft_pkg::CFG_RATE, 24'd1);
            default: write_reg(r2fft_pkg::CFG_RATE, 24'($urandom_range(1, 24'hFF_FFFF)));
        endcase
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(0, 9))
                0: smp = 16'sh7FFF;
                1: smp = -16'sh8000;
                default: smp = 16'($urandom_range(0, 16'hFFFF));
            endcase
            put_sample(smp, $urandom_range(0, 9) == 0, idle_pct);
        end
        // Close any open frame so the phase ends idle.
        put_sample(16'($urandom_range(0, 16'hFFFF)), 1'b1, idle_pct);
        drain();
    endtask

    initial begin
        #60_000_000;
        $display("radix2_fft_magnitude_spectrum regression: fail");
        $finish;
    end

    initial begin
        sb = new();
        samples_sent = 0;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_sample    <= '0;
        i_frame_end <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= r2fft_pkg::CFG_SIZE;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: short frame with sample extremes, zero padded.
        put_sample(16'sh7FFF, 1'b0, 0);
        put_sample(-16'sh8000, 1'b0, 0);
        put_sample(16'sh0000, 1'b1, 0);
        drain();
        // Two points of full negative scale saturate the magnitude.
        write_reg(r2fft_pkg::CFG_SIZE, 24'd1);
        put_sample(-16'sh8000, 1'b0, 0);
        put_sample(-16'sh8000, 1'b0, 0);
        drain();
        // Size zero behaves as size one.
        write_reg(r2fft_pkg::CFG_SIZE, 24'd0);
        put_sample(16'sh7FFF, 1'b1, 0);
        drain();
        // Window on, top rate; the final window weight is zero.
        write_reg(r2fft_pkg::CFG_WINDOW, 24'd1);
        write_reg(r2fft_pkg::CFG_RATE, 24'hFF_FFFF);
        write_reg(r2fft_pkg::CFG_SIZE, 24'd2);
        repeat (4) put_sample(16'sh7FFF, 1'b0, 0);
        drain();
        // Zero rate; a size write in mid frame drops the partial frame.
        write_reg(r2fft_pkg::CFG_WINDOW, 24'd0);
        write_reg(r2fft_pkg::CFG_RATE, 24'd0);
        write_reg(r2fft_pkg::CFG_SIZE, 24'd3);
        put_sample(16'sh1234, 1'b0, 0);
        drain();
        write_reg(r2fft_pkg::CFG_SIZE, 24'd3);
        write_reg(CFG_SPARE, 24'hFF_FFFF);
        for (int i = 0; i < 8; i++) put_sample(16'(16'sh0100 * (i - 4)), 1'b0, 0);
        drain();

        // Random phases at different sender idle rates.
        random_phase(35, 0);
        random_phase(35, 77);
        random_phase(35, 0);
        random_phase(35, 34);
        drain();

        $display("Sent %0d samples in %0d frames; %0d bins checked.",
                 samples_sent, sb.frames_closed, sb.bins_seen);
        $display("Sizes 0 to 7, window on and off, rates from 0 to full scale.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("radix2_fft_magnitude_spectrum regression: pass");
        end else begin
            $display("radix2_fft_magnitude_spectrum regression: fail");
        end
        $finish;
    end
endmodule
